### sv/combination_rank_unrank_assert.svh
// ----------------------------------------------------------------------------
// combination rank/unrank assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef COMBINATION_RANK_UNRANK_ASSERT_SVH
`define COMBINATION_RANK_UNRANK_ASSERT_SVH

`ifndef SYNTHESIS
`define CRR_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("combination_rank_unrank assertion failed");
`define CRR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("combination_rank_unrank assertion failed");
`else
`define CRR_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define CRR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

### sv/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg
// shared widths, codes, interface structs and the pascal table builder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crr_pkg;

	localparam int MAX_POSITIONS = 32;
	localparam int TBL_N         = MAX_POSITIONS + 1;
	localparam int VEC_W         = 32;
	localparam int IDX_W         = 30;
	localparam int ACC_W         = IDX_W + 1;
	localparam int CFG_W         = 6;
	localparam int CFG_IDX_W     = 2;
	localparam int D_W           = $clog2(VEC_W);

	localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PARTICLES = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		CMD_RANK,
		CMD_UNRANK,
		CMD_NEXT,
		CMD_FIRST
	} cmd_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic             lt;
		logic [ACC_W-1:0] res;
	} alu_rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] row;
		logic [CFG_W-1:0] col;
	} rom_addr_t;

	typedef logic [TBL_N*TBL_N-1:0][IDX_W-1:0] pascal_tbl_t;

	// row-major table, entry i*TBL_N+j holds C(i, j)
	function automatic pascal_tbl_t build_pascal();
		pascal_tbl_t t;
		t = '0;
		for (int i = 0; i < TBL_N; i++) begin
			t[i*TBL_N] = IDX_W'(1);
			for (int j = 1; j <= i; j++) begin
				t[i*TBL_N+j] = t[(i-1)*TBL_N+j-1] + t[(i-1)*TBL_N+j];
			end
		end
		return t;
	endfunction

endpackage

### sv/crr_binom_rom.sv
// ----------------------------------------------------------------------------
// crr_binom_rom
// binomial coefficient rom, two read ports, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crr_binom_rom (
	input  logic                    clk,
	input  crr_pkg::rom_addr_t      addr_a,
	input  crr_pkg::rom_addr_t      addr_b,
	output logic [crr_pkg::IDX_W-1:0] data_a,
	output logic [crr_pkg::IDX_W-1:0] data_b
);

	localparam int ROM_AW = $clog2(crr_pkg::TBL_N * crr_pkg::TBL_N);
	localparam crr_pkg::pascal_tbl_t PASCAL = crr_pkg::build_pascal();

	logic [ROM_AW-1:0] idx_a;
	logic [ROM_AW-1:0] idx_b;
	logic              hit_a;
	logic              hit_b;

	assign hit_a = (addr_a.row < crr_pkg::CFG_W'(crr_pkg::TBL_N)) &&
		(addr_a.col < crr_pkg::CFG_W'(crr_pkg::TBL_N));
	assign hit_b = (addr_b.row < crr_pkg::CFG_W'(crr_pkg::TBL_N)) &&
		(addr_b.col < crr_pkg::CFG_W'(crr_pkg::TBL_N));
	assign idx_a = ROM_AW'(addr_a.row) * ROM_AW'(crr_pkg::TBL_N) + ROM_AW'(addr_a.col);
	assign idx_b = ROM_AW'(addr_b.row) * ROM_AW'(crr_pkg::TBL_N) + ROM_AW'(addr_b.col);

	// out of table reads as zero
	always_ff @(posedge clk) begin
		data_a <= hit_a ? PASCAL[idx_a] : '0;
		data_b <= hit_b ? PASCAL[idx_b] : '0;
	end

endmodule

### sv/crr_alu.sv
// ----------------------------------------------------------------------------
// crr_alu
// shared add/subtract unit, subtract also reports a < b
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crr_alu (
	input  crr_pkg::alu_req_t req,
	output crr_pkg::alu_rsp_t rsp
);

	logic [crr_pkg::ACC_W:0] sum;

	always_comb begin
		case (req.op)
			crr_pkg::ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
			crr_pkg::ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
			default:          sum = '0;
		endcase
		rsp.res = sum[crr_pkg::ACC_W-1:0];
		rsp.lt  = (req.op == crr_pkg::ALU_SUB) && sum[crr_pkg::ACC_W];
	end

endmodule

### sv/combination_rank_unrank.sv
// ----------------------------------------------------------------------------
// combination_rank_unrank
// from accept to result valid: first, bad settings or a bad unrank index
// go straight to output; unrank walks the positions, rank walks all 32
// vector bits, next ranks, steps the index and unranks it or wraps to first
// a new word is taken the cycle after the result is loaded; each walk step
// passes through the shared alu and rom
// reset: arst_n async, positions 8, particles 4, no result pending
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "combination_rank_unrank_assert.svh"

module combination_rank_unrank (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [crr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [crr_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [1:0]                    command,
	input  logic [crr_pkg::VEC_W-1:0]     state_vector,
	input  logic [crr_pkg::IDX_W-1:0]     rank_index,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [crr_pkg::VEC_W-1:0]     result_vector,
	output logic [crr_pkg::IDX_W-1:0]     result_index,
	output logic                          is_first,
	output logic                          invalid
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CARD,
		S_CARDW,
		S_RANK,
		S_RFL,
		S_RINC,
		S_RCHK,
		S_UPRE,
		S_UNRANK,
		S_OUT
	} state_t;

	state_t                      state_q;
	crr_pkg::cmd_t               cmd_q;
	logic [crr_pkg::VEC_W-1:0]   sv_q;
	logic [crr_pkg::VEC_W-1:0]   shift_q;
	logic [crr_pkg::IDX_W-1:0]   ri_q;
	logic [crr_pkg::IDX_W-1:0]   card_q;
	logic [crr_pkg::ACC_W-1:0]   acc_q;
	logic [crr_pkg::ACC_W-1:0]   idx_q;
	logic [crr_pkg::IDX_W-1:0]   rx_q;
	logic [crr_pkg::CFG_W-1:0]   left_q;
	logic [crr_pkg::CFG_W-1:0]   pop_q;
	logic [crr_pkg::D_W-1:0]     d_q;
	logic                        flag_q;
	logic                        prev_one_q;
	logic [crr_pkg::VEC_W-1:0]   vec_q;
	logic [crr_pkg::VEC_W-1:0]   res_vec_q;
	logic [crr_pkg::IDX_W-1:0]   res_idx_q;
	logic                        res_bad_q;
	logic                        res_valid_q;
	logic [crr_pkg::VEC_W-1:0]   result_vector_q;
	logic [crr_pkg::IDX_W-1:0]   result_index_q;
	logic                        is_first_q;
	logic                        invalid_q;
	logic [crr_pkg::CFG_W-1:0]   positions_q;
	logic [crr_pkg::CFG_W-1:0]   particles_q;

	crr_pkg::rom_addr_t          addr_a;
	crr_pkg::rom_addr_t          addr_b;
	logic [crr_pkg::IDX_W-1:0]   rom_a;
	logic [crr_pkg::IDX_W-1:0]   rom_b;
	crr_pkg::alu_req_t           alu_req;
	crr_pkg::alu_rsp_t           alu_rsp;
	logic                        cfg_bad;
	logic [crr_pkg::VEC_W-1:0]   fv;
	logic                        in_range;
	logic [crr_pkg::IDX_W-1:0]   thr;
	logic [crr_pkg::VEC_W-1:0]   vec_nx;
	logic [crr_pkg::CFG_W-1:0]   d_ext;

	assign cfg_bad = (positions_q == '0) ||
		(positions_q > crr_pkg::CFG_W'(crr_pkg::MAX_POSITIONS)) ||
		(particles_q > positions_q);
	assign fv       = ~({crr_pkg::VEC_W{1'b1}} << particles_q);
	assign d_ext    = crr_pkg::CFG_W'(d_q);
	assign in_range = d_ext < positions_q;
	assign thr      = (left_q == '0) ? '0 : (prev_one_q ? rom_b : rom_a);
	assign vec_nx   = vec_q | (crr_pkg::VEC_W'(alu_rsp.lt) << d_q);

	assign cmd_stall     = (state_q != S_IDLE);
	assign res_valid     = res_valid_q;
	assign result_vector = result_vector_q;
	assign result_index  = result_index_q;
	assign is_first      = is_first_q;
	assign invalid       = invalid_q;

	// rom address selection
	always_comb begin
		addr_a.row = positions_q;
		addr_a.col = particles_q;
		addr_b.row = '0;
		addr_b.col = '0;
		case (state_q)
			S_RANK: begin
				addr_a.row = positions_q - crr_pkg::CFG_W'(1) - d_ext;
				addr_a.col = left_q - crr_pkg::CFG_W'(1);
			end
			S_UPRE: begin
				addr_a.row = positions_q - crr_pkg::CFG_W'(1);
				addr_a.col = particles_q - crr_pkg::CFG_W'(1);
			end
			S_UNRANK: begin
				addr_a.row = positions_q - crr_pkg::CFG_W'(2) - d_ext;
				addr_a.col = left_q - crr_pkg::CFG_W'(1);
				addr_b.row = positions_q - crr_pkg::CFG_W'(2) - d_ext;
				addr_b.col = left_q - crr_pkg::CFG_W'(2);
			end
			default: begin
			end
		endcase
	end

	// alu operand selection
	always_comb begin
		alu_req.op = crr_pkg::ALU_ADD;
		alu_req.a  = acc_q;
		alu_req.b  = '0;
		case (state_q)
			S_CARDW: begin
				alu_req.op = crr_pkg::ALU_SUB;
				alu_req.a  = crr_pkg::ACC_W'(ri_q);
				alu_req.b  = crr_pkg::ACC_W'(rom_a);
			end
			S_RANK, S_RFL: begin
				alu_req.b = flag_q ? crr_pkg::ACC_W'(rom_a) : '0;
			end
			S_RINC: begin
				alu_req.b = crr_pkg::ACC_W'(1);
			end
			S_RCHK: begin
				alu_req.op = crr_pkg::ALU_SUB;
				alu_req.b  = crr_pkg::ACC_W'(card_q);
			end
			S_UNRANK: begin
				alu_req.op = crr_pkg::ALU_SUB;
				alu_req.a  = idx_q;
				alu_req.b  = crr_pkg::ACC_W'(thr);
			end
			default: begin
			end
		endcase
	end

	crr_binom_rom u_rom (
		.clk    (clk),
		.addr_a (addr_a),
		.addr_b (addr_b),
		.data_a (rom_a),
		.data_b (rom_b)
	);

	crr_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			positions_q <= crr_pkg::CFG_W'(8);
			particles_q <= crr_pkg::CFG_W'(4);
		end else if (cfg_we) begin
			case (cfg_index)
				crr_pkg::CFG_POSITIONS: positions_q <= cfg_data;
				crr_pkg::CFG_PARTICLES: particles_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			res_valid_q     <= 1'b0;
			cmd_q           <= crr_pkg::CMD_RANK;
			sv_q            <= '0;
			shift_q         <= '0;
			ri_q            <= '0;
			card_q          <= '0;
			acc_q           <= '0;
			idx_q           <= '0;
			rx_q            <= '0;
			left_q          <= '0;
			pop_q           <= '0;
			d_q             <= '0;
			flag_q          <= 1'b0;
			prev_one_q      <= 1'b0;
			vec_q           <= '0;
			res_vec_q       <= '0;
			res_idx_q       <= '0;
			res_bad_q       <= 1'b0;
			result_vector_q <= '0;
			result_index_q  <= '0;
			is_first_q      <= 1'b0;
			invalid_q       <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && (state_q != S_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q     <= crr_pkg::cmd_t'(command);
						sv_q      <= state_vector;
						shift_q   <= state_vector;
						ri_q      <= rank_index;
						res_bad_q <= 1'b0;
						state_q   <= S_CARD;
					end
				end
				S_CARD: begin
					state_q <= S_CARDW;
				end
				S_CARDW: begin
					card_q <= rom_a;
					acc_q  <= '0;
					pop_q  <= '0;
					d_q    <= '0;
					left_q <= particles_q;
					flag_q <= 1'b0;
					if (cfg_bad) begin
						res_bad_q <= 1'b1;
						state_q   <= S_OUT;
					end else begin
						case (cmd_q)
							crr_pkg::CMD_FIRST: begin
								res_vec_q <= fv;
								res_idx_q <= '0;
								state_q   <= S_OUT;
							end
							crr_pkg::CMD_UNRANK: begin
								if (alu_rsp.lt) begin
									idx_q   <= crr_pkg::ACC_W'(ri_q);
									rx_q    <= ri_q;
									state_q <= S_UPRE;
								end else begin
									res_bad_q <= 1'b1;
									state_q   <= S_OUT;
								end
							end
							default: begin
								state_q <= S_RANK;
							end
						endcase
					end
				end
				S_RANK: begin
					acc_q   <= alu_rsp.res;
					pop_q   <= pop_q + crr_pkg::CFG_W'(shift_q[0]);
					flag_q  <= in_range && (left_q != '0) && !shift_q[0];
					if (in_range && (left_q != '0) && shift_q[0]) begin
						left_q <= left_q - crr_pkg::CFG_W'(1);
					end
					shift_q <= shift_q >> 1;
					d_q     <= d_q + crr_pkg::D_W'(1);
					if (d_q == crr_pkg::D_W'(crr_pkg::VEC_W - 1)) begin
						state_q <= S_RFL;
					end
				end
				S_RFL: begin
					acc_q <= alu_rsp.res;
					if (pop_q != particles_q) begin
						res_bad_q <= 1'b1;
						state_q   <= S_OUT;
					end else if (cmd_q == crr_pkg::CMD_RANK) begin
						res_vec_q <= '0;
						res_idx_q <= alu_rsp.res[crr_pkg::IDX_W-1:0];
						state_q   <= S_OUT;
					end else begin
						state_q <= S_RINC;
					end
				end
				S_RINC: begin
					acc_q   <= alu_rsp.res;
					state_q <= S_RCHK;
				end
				S_RCHK: begin
					if (alu_rsp.lt) begin
						idx_q   <= acc_q;
						rx_q    <= acc_q[crr_pkg::IDX_W-1:0];
						state_q <= S_UPRE;
					end else begin
						res_vec_q <= fv;
						res_idx_q <= '0;
						state_q   <= S_OUT;
					end
				end
				S_UPRE: begin
					d_q        <= '0;
					left_q     <= particles_q;
					vec_q      <= '0;
					prev_one_q <= 1'b0;
					state_q    <= S_UNRANK;
				end
				S_UNRANK: begin
					vec_q      <= vec_nx;
					prev_one_q <= alu_rsp.lt;
					if (alu_rsp.lt) begin
						left_q <= left_q - crr_pkg::CFG_W'(1);
					end else begin
						idx_q <= alu_rsp.res;
					end
					d_q <= d_q + crr_pkg::D_W'(1);
					if (d_ext == positions_q - crr_pkg::CFG_W'(1)) begin
						res_vec_q <= vec_nx;
						res_idx_q <= rx_q;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (!res_valid_q || !res_stall) begin
						result_vector_q <= res_bad_q ? '0 : res_vec_q;
						result_index_q  <= res_bad_q ? '0 : res_idx_q;
						is_first_q      <= !res_bad_q && (sv_q == fv);
						invalid_q       <= res_bad_q;
						res_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`CRR_ASSERT_NEXT(a_accept_starts, clk, arst_n, cmd_valid && !cmd_stall, state_q == S_CARD)
	`CRR_ASSERT_IMPL(a_invalid_zero, clk, arst_n, res_valid && invalid, result_vector == '0 && result_index == '0 && !is_first)
	`CRR_ASSERT_IMPL(a_rise_from_out, clk, arst_n, $rose(res_valid), $past(state_q) == S_OUT)

endmodule
